[hw/rtl/rid_pkg.sv]
package rid_pkg;

   localparam int POINTS      = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int IN_BITS   = 16;
   localparam int BIN_BITS  = 6;
   localparam int OUT_BITS  = 39;
   localparam int TW_BITS   = 16;
   localparam int IDX_BITS  = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int PROD_BITS = SAMPLE_BITS + TW_BITS;
   localparam int ACC_BITS  = PROD_BITS + IDX_BITS;
   localparam int SAT_BITS  = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   localparam logic signed [SAT_BITS-1:0] SAT_HI =
      {{(SAT_BITS-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [SAT_BITS-1:0] SAT_LO =
      {{(SAT_BITS-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

   typedef logic [POINTS-1:0][TW_BITS-1:0] twiddle_table_type;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic issue;
   } rid_cmd_type;

   typedef struct packed {
      logic load_last;
      logic scan_last;
   } rid_status_type;

   // unsigned shift-and-subtract quotient
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // first-quadrant sine (odd) or cosine, Q2.30 in and out
   function automatic logic [63:0] series_q30(logic [63:0] a, bit odd);
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] n;
      bit          add;
      term = odd ? a : ONE_Q30;
      acc  = term;
      n    = odd ? 64'd1 : 64'd0;
      add  = 1'b0;
      for (int i = 0; i < 10; i++) begin
         term = udiv64((term * a) >> 30, n + 64'd1);
         term = udiv64((term * a) >> 30, n + 64'd2);
         n    = n + 64'd2;
         if (add) begin
            acc = acc + term;
         end else begin
            acc = (acc > term) ? acc - term : 64'd0;
         end
         add = !add;
      end
      return acc;
   endfunction

   function automatic logic [TW_BITS-1:0] to_q15(logic [63:0] mag, bit neg);
      logic [63:0] m;
      m = (mag + (64'd1 << 14)) >> 15;
      if (neg) begin
         return TW_BITS'(64'd0 - m);
      end
      return (m > 64'd32767) ? TW_BITS'(32767) : TW_BITS'(m);
   endfunction

   function automatic twiddle_table_type build_table(bit want_sin);
      twiddle_table_type t;
      logic [63:0]       q4;
      logic [1:0]        quad;
      logic [63:0]       r;
      logic [63:0]       a;
      logic [63:0]       c;
      logic [63:0]       s;
      logic [TW_BITS-1:0] cv;
      logic [TW_BITS-1:0] sv;
      t = '0;
      for (int m = 0; m < POINTS; m++) begin
         q4   = 64'(4 * m);
         quad = 2'(q4 / POINTS);
         r    = q4 % POINTS;
         a    = (HALF_PI_Q30 * r) / POINTS;
         c    = series_q30(a, 1'b0);
         s    = series_q30(a, 1'b1);
         case (quad)
            2'd0: begin
               cv = to_q15(c, 1'b0);
               sv = to_q15(s, 1'b0);
            end
            2'd1: begin
               cv = to_q15(s, 1'b1);
               sv = to_q15(c, 1'b0);
            end
            2'd2: begin
               cv = to_q15(c, 1'b1);
               sv = to_q15(s, 1'b1);
            end
            default: begin
               cv = to_q15(s, 1'b0);
               sv = to_q15(c, 1'b1);
            end
         endcase
         t[m] = want_sin ? sv : cv;
      end
      return t;
   endfunction

   localparam twiddle_table_type COS_TABLE = build_table(1'b0);
   localparam twiddle_table_type SIN_TABLE = build_table(1'b1);

   function automatic logic signed [SAMPLE_BITS-1:0] take_sample(logic [IN_BITS-1:0] x);
      logic [SAMPLE_BITS-1:0] raw;
      raw = '0;
      for (int i = 0; i < SAMPLE_BITS && i < IN_BITS; i++) begin
         raw[i] = x[i];
      end
      return $signed(raw);
   endfunction

   function automatic logic [OUT_BITS-1:0] saturate(logic signed [ACC_BITS-1:0] v);
      logic signed [SAT_BITS-1:0] w;
      w = SAT_BITS'(v);
      if (w > SAT_HI) begin
         w = SAT_HI;
      end else if (w < SAT_LO) begin
         w = SAT_LO;
      end
      return w[OUT_BITS-1:0];
   endfunction

endpackage

[hw/rtl/rid_controller.sv]
module rid_controller
   import rid_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  rid_status_type status,
   output rid_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.scan_clear = 1'b0;
      cmd.issue      = 1'b0;
      busy           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.load_last) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            busy      = 1'b1;
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            busy     = 1'b1;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/rid_datapath.sv]
module rid_datapath
   import rid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  rid_cmd_type                cmd,
   input  logic [IN_BITS-1:0]         sample,
   output rid_status_type             status,
   output logic                       out_valid,
   output logic [BIN_BITS-1:0]        out_bin,
   output logic signed [OUT_BITS-1:0] out_real,
   output logic signed [OUT_BITS-1:0] out_imag,
   output logic                       out_last
);

   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(POINTS - 1);

   logic signed [SAMPLE_BITS-1:0] mem [POINTS];

   logic [IDX_BITS-1:0] load_cnt_ff, load_cnt_in;
   logic [IDX_BITS-1:0] n_ff, n_in;
   logic [IDX_BITS-1:0] k_ff, k_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [IDX_BITS:0]   idx_sum;

   // stage 1: operands fetched
   logic                          v1_ff, first1_ff, last1_ff;
   logic [IDX_BITS-1:0]           k1_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic signed [TW_BITS-1:0]     cos1_ff, sin1_ff;

   // stage 2: products
   logic                        v2_ff, first2_ff, last2_ff;
   logic [IDX_BITS-1:0]         k2_ff;
   logic signed [PROD_BITS-1:0] pre_ff, pim_ff;

   // stage 3: accumulators
   logic                       v3_ff;
   logic [IDX_BITS-1:0]        k3_ff;
   logic signed [ACC_BITS-1:0] re_acc_ff, im_acc_ff;
   logic signed [ACC_BITS-1:0] re_base, im_base;

   assign status.load_last = (load_cnt_ff == LAST_IDX);
   assign status.scan_last = (n_ff == LAST_IDX) && (k_ff == LAST_IDX);

   assign idx_sum = {1'b0, idx_ff} + {1'b0, k_ff};

   always_comb begin
      load_cnt_in = load_cnt_ff;
      if (cmd.load) begin
         load_cnt_in = status.load_last ? '0 : load_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      n_in   = n_ff;
      k_in   = k_ff;
      idx_in = idx_ff;
      if (cmd.scan_clear) begin
         n_in   = '0;
         k_in   = '0;
         idx_in = '0;
      end else if (cmd.issue) begin
         if (n_ff == LAST_IDX) begin
            n_in   = '0;
            idx_in = '0;
            k_in   = k_ff + 1'b1;
         end else begin
            n_in = n_ff + 1'b1;
            if (idx_sum >= (IDX_BITS+1)'(POINTS)) begin
               idx_in = IDX_BITS'(idx_sum - (IDX_BITS+1)'(POINTS));
            end else begin
               idx_in = idx_sum[IDX_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[load_cnt_ff] <= take_sample(sample);
      end
      rd_ff <= mem[n_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         idx_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         n_ff        <= n_in;
         k_ff        <= k_in;
         idx_ff      <= idx_in;
         v1_ff       <= cmd.issue;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff && last2_ff;
      end
   end

   assign re_base = first2_ff ? '0 : re_acc_ff;
   assign im_base = first2_ff ? '0 : im_acc_ff;

   always_ff @(posedge clock) begin
      first1_ff <= (n_ff == '0);
      last1_ff  <= (n_ff == LAST_IDX);
      k1_ff     <= k_ff;
      cos1_ff   <= $signed(COS_TABLE[idx_ff]);
      sin1_ff   <= $signed(SIN_TABLE[idx_ff]);

      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      k2_ff     <= k1_ff;
      pre_ff    <= rd_ff * cos1_ff;
      pim_ff    <= rd_ff * sin1_ff;

      if (v2_ff) begin
         re_acc_ff <= re_base + ACC_BITS'(pre_ff);
         im_acc_ff <= im_base - ACC_BITS'(pim_ff);
         k3_ff     <= k2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_bin   = BIN_BITS'(k3_ff);
   assign out_real  = $signed(saturate(re_acc_ff));
   assign out_imag  = $signed(saturate(im_acc_ff));
   assign out_last  = (k3_ff == LAST_IDX);

endmodule

[hw/rtl/real_input_dft.sv]
// Direct DFT of POINTS real samples. While busy is low one sample is taken per
// cycle that start is high. The POINTS-th sample of a block raises busy for
// the scan over every bin and sample, one complex multiply-accumulate per
// cycle through a single pair of multipliers and a sample memory with one
// read port. Bin k appears on the rsp_ ports for one cycle with rsp_valid
// high, one bin at a time in ascending order; the last bin, flagged by
// rsp_last_bin, arrives after busy falls, once its final product has passed
// the fetch, product and accumulate registers. Results cannot be held off:
// the receiver must take each one in the cycle it is shown.
module real_input_dft
   import rid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [IN_BITS-1:0]         req_sample,
   output logic                       rsp_valid,
   output logic [BIN_BITS-1:0]        rsp_bin_index,
   output logic signed [OUT_BITS-1:0] rsp_real_part,
   output logic signed [OUT_BITS-1:0] rsp_imag_part,
   output logic                       rsp_last_bin
);

   rid_cmd_type    cmd;
   rid_status_type status;

   rid_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   rid_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req_sample),
      .status    (status),
      .out_valid (rsp_valid),
      .out_bin   (rsp_bin_index),
      .out_real  (rsp_real_part),
      .out_imag  (rsp_imag_part),
      .out_last  (rsp_last_bin)
   );

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted request");

   a_bins_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |-> busy)
      else $error("intermediate bin outside the scan");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |=> !rsp_valid && !busy)
      else $error("result or scan straight after the last bin");

endmodule
